// ===== hdl/utrf_pkg.sv =====
package utrf_pkg;

  localparam int FifoDepth = 64;
  localparam int PtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int FillW     = (PtrW > 6) ? PtrW : 6;

  localparam int TickW = 20;

  typedef logic [PtrW-1:0]  fifo_ptr_t;
  typedef logic [TickW-1:0] tick_t;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhStart  = 3'd1,
    PhData   = 3'd2,
    PhParity = 3'd3,
    PhStop   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    RdOk    = 2'd0,
    RdEmpty = 2'd1,
    RdOff   = 2'd2
  } rd_status_e;

  localparam logic [1:0] ParNone = 2'd0;
  localparam logic [1:0] ParEven = 2'd1;
  localparam logic [1:0] ParOdd  = 2'd2;

  localparam logic [2:0] RegBitTicks  = 3'd0;
  localparam logic [2:0] RegDataBits  = 3'd1;
  localparam logic [2:0] RegStopCount = 3'd2;
  localparam logic [2:0] RegParity    = 3'd3;
  localparam logic [2:0] RegEnable    = 3'd4;

  typedef struct packed {
    tick_t      ticks;
    logic [3:0] nbits;
    logic       two_stop;
    logic [1:0] parity;
    logic       enable;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } push_t;

  typedef struct packed {
    logic level;
    logic taken;
    logic busy;
  } tx_out_t;

  function automatic logic [7:0] char_mask(logic [3:0] nbits);
    logic [7:0] m;
    unique case (nbits)
      4'd5:    m = 8'h1F;
      4'd6:    m = 8'h3F;
      4'd7:    m = 8'h7F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  function automatic fifo_ptr_t ptr_next(fifo_ptr_t p);
    fifo_ptr_t r;
    if (p == fifo_ptr_t'(FifoDepth - 1)) begin
      r = '0;
    end else begin
      r = p + fifo_ptr_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== hdl/uart_transceiver_with_rx_fifo.sv =====
// Full-duplex UART that advances by one timebase tick per accepted request,
// and accepts one request every clock cycle as long as the result side keeps
// up. Each result is registered and appears the cycle after its request; a
// stalled result holds the input side only until it is taken. Received bytes
// live in a single-port-write, registered-read RAM of FifoDepth entries that
// holds FifoDepth-1 bytes; a pop reads the head slot at the accept edge and
// the byte shows up with the result. Writing any configuration register
// empties the FIFO, clears the overflow flag and aborts frames in flight, so
// write configuration only while the stream is quiet.
module uart_transceiver_with_rx_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] rx_level, [1] send_valid, [9:2] send_byte, [10] read_req
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] tx_level, [1] send_taken, [2] tx_busy, [4:3] read_status,
  // [12:5] read_data, [18:13] fill_level, [19] overflow
  output logic [23:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import utrf_pkg::*;

  tick_t      bit_ticks_q;
  logic [3:0] data_bits_q;
  logic [1:0] stop_count_q;
  logic [1:0] parity_mode_q;
  logic       enable_q;
  cfg_t       cfg;
  logic       cfg_wr;
  logic       cfg_clr;
  logic [2:0] reg_idx;

  logic       step;
  logic       rx_level, send_valid, read_req;
  logic [7:0] send_byte;
  push_t      push;
  tx_out_t    tx_out;

  fifo_ptr_t  head_q, head_d, tail_q, tail_d, head_pop, tail_nx;
  logic       ovf_q, ovf_d;
  logic       empty, pop, full, ram_we, ram_re;
  rd_status_e status;
  logic [7:0] ram_rdata;
  fifo_ptr_t  fill;
  logic [FillW-1:0] fill_ext;

  logic       m_valid_q;
  logic       txl_q, taken_q, busy_q, pop_q, ovf_out_q;
  rd_status_e status_q;
  logic [5:0] fill_q;
  logic [7:0] read_data;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_clr = cfg_wr && (reg_idx <= RegEnable);

  always_comb begin
    unique case (reg_idx)
      RegBitTicks:  prdata = 32'(bit_ticks_q);
      RegDataBits:  prdata = 32'(data_bits_q);
      RegStopCount: prdata = 32'(stop_count_q);
      RegParity:    prdata = 32'(parity_mode_q);
      RegEnable:    prdata = 32'(enable_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q   <= tick_t'(104);
      data_bits_q   <= 4'd8;
      stop_count_q  <= 2'd1;
      parity_mode_q <= ParNone;
      enable_q      <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegBitTicks:  bit_ticks_q   <= pwdata[TickW-1:0];
        RegDataBits:  data_bits_q   <= pwdata[3:0];
        RegStopCount: stop_count_q  <= pwdata[1:0];
        RegParity:    parity_mode_q <= pwdata[1:0];
        RegEnable:    enable_q      <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    cfg.ticks    = (bit_ticks_q == '0) ? tick_t'(1) : bit_ticks_q;
    cfg.nbits    = (data_bits_q >= 4'd5 && data_bits_q <= 4'd8) ? data_bits_q : 4'd8;
    cfg.two_stop = (stop_count_q == 2'd2);
    cfg.parity   = (parity_mode_q == 2'd3) ? ParNone : parity_mode_q;
    cfg.enable   = enable_q;
  end

  // Request fields.
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign step            = s_axis_tvalid_i && s_axis_tready_o;
  assign rx_level        = s_axis_tdata_i[0];
  assign send_valid      = s_axis_tdata_i[1];
  assign send_byte       = s_axis_tdata_i[9:2];
  assign read_req        = s_axis_tdata_i[10];

  utrf_rx u_rx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .clear_i (cfg_clr),
    .cfg_i   (cfg),
    .level_i (rx_level),
    .push_o  (push)
  );

  utrf_tx u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .clear_i      (cfg_clr),
    .cfg_i        (cfg),
    .send_valid_i (send_valid),
    .send_byte_i  (send_byte),
    .tx_o         (tx_out)
  );

  // FIFO control: the pop is served before the push of the same tick.
  always_comb begin
    empty = (head_q == tail_q);
    pop   = enable_q && !empty && read_req;
    if (!enable_q) begin
      status = RdOff;
    end else if (pop) begin
      status = RdOk;
    end else begin
      status = RdEmpty;
    end
    head_pop = pop ? ptr_next(head_q) : head_q;
    tail_nx  = ptr_next(tail_q);
    full     = (tail_nx == head_pop);
    ram_we   = step && push.valid && !full;
    ram_re   = step && pop;
    head_d   = step ? head_pop : head_q;
    tail_d   = ram_we ? tail_nx : tail_q;
    ovf_d    = ovf_q || (step && push.valid && full);
    if (tail_d >= head_d) begin
      fill = tail_d - head_d;
    end else begin
      fill = tail_d - head_d + fifo_ptr_t'(FifoDepth);
    end
    fill_ext = FillW'(fill);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      ovf_q  <= 1'b0;
    end else if (cfg_clr) begin
      head_q <= '0;
      tail_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      ovf_q  <= ovf_d;
    end
  end

  utrf_ram #(
    .Width (8),
    .Depth (FifoDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (push.data),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (step) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      txl_q     <= tx_out.level;
      taken_q   <= tx_out.taken;
      busy_q    <= tx_out.busy;
      status_q  <= status;
      pop_q     <= pop;
      fill_q    <= fill_ext[5:0];
      ovf_out_q <= ovf_d;
    end
  end

  assign read_data       = pop_q ? ram_rdata : 8'h00;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0000, ovf_out_q, fill_q, read_data, status_q,
                            busy_q, taken_q, txl_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (head_q != tail_q))
    else $error("FIFO write and read hit the same slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_clr |=> (head_q == tail_q) && !ovf_q)
    else $error("configuration write did not empty the FIFO");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("new request taken while a result is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && pop) |=> (status_q == RdOk) && pop_q)
    else $error("pop not reflected in the result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !enable_q) |=> (status_q == RdOff) && !taken_q)
    else $error("disabled block served a request");

endmodule

// ===== hdl/utrf_ram.sv =====
module utrf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/utrf_rx.sv =====
module utrf_rx (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            clear_i,
  input  utrf_pkg::cfg_t  cfg_i,
  input  logic            level_i,
  output utrf_pkg::push_t push_o
);
  import utrf_pkg::*;

  phase_e     phase_q, phase_d;
  tick_t      timer_q, timer_d;
  logic [2:0] idx_q, idx_d;
  logic [7:0] shift_q, shift_d;
  logic       prev_q;
  logic       expire;
  logic       last_bit;
  logic       par_calc;
  logic       par_bad;

  assign expire   = (timer_q <= tick_t'(1));
  assign last_bit = ({1'b0, idx_q} + 4'd1) >= cfg_i.nbits;
  assign par_calc = ^shift_q;
  assign par_bad  = (cfg_i.parity == ParEven) ? (par_calc != level_i) : (par_calc == level_i);

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    if (cfg_i.enable) begin
      if (phase_q != PhIdle) begin
        timer_d = expire ? '0 : timer_q - tick_t'(1);
      end
      unique case (phase_q)
        PhIdle: begin
          if (prev_q && !level_i) begin
            shift_d = '0;
            idx_d   = '0;
            if (cfg_i.ticks[TickW-1:1] == '0) begin
              phase_d = PhData;
              timer_d = cfg_i.ticks;
            end else begin
              phase_d = PhStart;
              timer_d = {1'b0, cfg_i.ticks[TickW-1:1]};
            end
          end
        end
        PhStart: begin
          if (expire) begin
            phase_d = PhData;
            timer_d = cfg_i.ticks;
          end
        end
        PhData: begin
          if (expire) begin
            if (level_i) begin
              shift_d[idx_q] = 1'b1;
            end
            if (last_bit) begin
              phase_d = (cfg_i.parity != ParNone) ? PhParity : PhStop;
              idx_d   = '0;
            end else begin
              idx_d = idx_q + 3'd1;
            end
            timer_d = cfg_i.ticks;
          end
        end
        PhParity: begin
          if (expire) begin
            if (par_bad) begin
              phase_d = PhIdle;
            end else begin
              phase_d = PhStop;
              timer_d = cfg_i.ticks;
            end
          end
        end
        PhStop: begin
          if (expire) begin
            phase_d = PhIdle;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_comb begin
    push_o.valid = step_i && cfg_i.enable && (phase_q == PhStop) && expire && level_i;
    push_o.data  = shift_q & char_mask(cfg_i.nbits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      timer_q <= '0;
      idx_q   <= '0;
      shift_q <= '0;
      prev_q  <= 1'b1;
    end else begin
      if (clear_i) begin
        phase_q <= PhIdle;
        timer_q <= '0;
        idx_q   <= '0;
        shift_q <= '0;
      end else if (step_i) begin
        phase_q <= phase_d;
        timer_q <= timer_d;
        idx_q   <= idx_d;
        shift_q <= shift_d;
      end
      if (step_i) begin
        prev_q <= level_i;
      end
    end
  end

endmodule

// ===== hdl/utrf_tx.sv =====
module utrf_tx (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              clear_i,
  input  utrf_pkg::cfg_t    cfg_i,
  input  logic              send_valid_i,
  input  logic [7:0]        send_byte_i,
  output utrf_pkg::tx_out_t tx_o
);
  import utrf_pkg::*;

  phase_e     phase_q, phase_d, cur_phase;
  tick_t      timer_q, timer_d, cur_timer;
  logic [2:0] idx_q, idx_d, cur_idx;
  logic [7:0] shift_q, shift_d, cur_shift;
  logic       start;
  logic       expire;
  logic       last_bit;
  logic       last_stop;

  assign start     = cfg_i.enable && send_valid_i && (phase_q == PhIdle);
  assign cur_phase = start ? PhStart : phase_q;
  assign cur_timer = start ? cfg_i.ticks : timer_q;
  assign cur_idx   = start ? 3'd0 : idx_q;
  assign cur_shift = start ? (send_byte_i & char_mask(cfg_i.nbits)) : shift_q;
  assign expire    = (cur_timer <= tick_t'(1));
  assign last_bit  = ({1'b0, cur_idx} + 4'd1) >= cfg_i.nbits;
  assign last_stop = !cfg_i.two_stop || (cur_idx != 3'd0);

  always_comb begin
    phase_d = cur_phase;
    timer_d = cur_timer;
    idx_d   = cur_idx;
    shift_d = cur_shift;
    if (cur_phase != PhIdle) begin
      if (!expire) begin
        timer_d = cur_timer - tick_t'(1);
      end else begin
        timer_d = cfg_i.ticks;
        unique case (cur_phase)
          PhStart: begin
            phase_d = PhData;
            idx_d   = '0;
          end
          PhData: begin
            if (last_bit) begin
              phase_d = (cfg_i.parity != ParNone) ? PhParity : PhStop;
              idx_d   = '0;
            end else begin
              idx_d = cur_idx + 3'd1;
            end
          end
          PhParity: begin
            phase_d = PhStop;
            idx_d   = '0;
          end
          default: begin
            if (last_stop) begin
              phase_d = PhIdle;
              timer_d = '0;
              idx_d   = '0;
            end else begin
              idx_d = cur_idx + 3'd1;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    tx_o.taken = start;
    tx_o.busy  = (cur_phase != PhIdle);
    unique case (cur_phase)
      PhStart:  tx_o.level = 1'b0;
      PhData:   tx_o.level = cur_shift[cur_idx];
      PhParity: tx_o.level = (cfg_i.parity == ParEven) ? ^cur_shift : ~^cur_shift;
      default:  tx_o.level = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      timer_q <= '0;
      idx_q   <= '0;
      shift_q <= '0;
    end else if (clear_i) begin
      phase_q <= PhIdle;
      timer_q <= '0;
      idx_q   <= '0;
      shift_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
    end
  end

endmodule

// ===== tb/uart_transceiver_with_rx_fifo_tb.sv =====
module uart_transceiver_with_rx_fifo_tb;
  import utrf_pkg::*;

  localparam int StallLimit = 3000;
  localparam int ReportCap  = 100;
  localparam logic [2:0] RegUnused = 3'd7;

  typedef enum int {FrameGood, FrameBadParity, FrameBadStop} frame_kind_e;

  typedef struct {
    logic       rx_level;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       read_req;
  } tick_req_t;

  typedef struct {
    logic       tx_level;
    logic       send_taken;
    logic       tx_busy;
    rd_status_e read_status;
    logic [7:0] read_data;
    logic [5:0] fill_level;
    logic       overflow;
  } tick_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  uart_transceiver_with_rx_fifo dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk_i = ~clk_i;

  // Line state as the block should hold it.
  tick_t      ln_ticks;
  logic [3:0] ln_bits;
  logic [1:0] ln_stop;
  logic [1:0] ln_par;
  logic       ln_en;
  phase_e     rx_ph;
  tick_t      rx_tmr;
  logic [2:0] rx_idx;
  logic [7:0] rx_sr;
  logic       rx_last;
  logic [7:0] rx_bytes_q[$];
  logic       ovf_flag;
  phase_e     tx_ph;
  tick_t      tx_tmr;
  logic [2:0] tx_idx;
  logic [7:0] tx_sr;

  tick_rsp_t due_results[$];
  logic      line_q[$];

  int   mismatches = 0;
  int   ticks_done = 0;
  int   bytes_received = 0;
  int   overflow_hits = 0;
  int   sends_taken = 0;
  int   settings_run = 0;
  int   stall_cycles = 0;
  int   hold_left = 0;
  int   sink_gap = 0;
  logic src_jitter = 1'b0;
  logic sink_jitter = 1'b0;

  function automatic tick_t bit_len();
    return (ln_ticks == '0) ? tick_t'(1) : ln_ticks;
  endfunction

  function automatic int data_len();
    return (ln_bits >= 4'd5 && ln_bits <= 4'd8) ? int'(ln_bits) : 8;
  endfunction

  function automatic int stop_len();
    return (ln_stop == 2'd2) ? 2 : 1;
  endfunction

  function automatic logic [1:0] parity_kind();
    return (ln_par == ParEven || ln_par == ParOdd) ? ln_par : ParNone;
  endfunction

  function automatic logic [7:0] low_mask(int n);
    return 8'(16'h00FF >> (8 - n));
  endfunction

  function automatic logic timer_hit(inout tick_t t);
    if (t <= tick_t'(1)) begin
      t = '0;
      return 1'b1;
    end
    t = t - tick_t'(1);
    return 1'b0;
  endfunction

  function automatic void clear_line();
    rx_bytes_q.delete();
    ovf_flag = 1'b0;
    rx_ph = PhIdle;
    rx_tmr = '0;
    rx_idx = '0;
    rx_sr = '0;
    tx_ph = PhIdle;
    tx_tmr = '0;
    tx_idx = '0;
    tx_sr = '0;
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [31:0] val);
    logic hit;
    hit = 1'b1;
    case (idx)
      RegBitTicks:  ln_ticks = val[19:0];
      RegDataBits:  ln_bits = val[3:0];
      RegStopCount: ln_stop = val[1:0];
      RegParity:    ln_par = val[1:0];
      RegEnable:    ln_en = val[0];
      default:      hit = 1'b0;
    endcase
    if (hit) clear_line();
  endfunction

  function automatic void store_byte(logic [7:0] v);
    if (rx_bytes_q.size() >= FifoDepth - 1) begin
      ovf_flag = 1'b1;
      overflow_hits++;
    end else begin
      rx_bytes_q.push_back(v);
      bytes_received++;
    end
  endfunction

  function automatic void rx_advance(logic level);
    tick_t      b;
    int         nb;
    logic [1:0] pk;
    logic       fire;
    logic       calc;
    b = bit_len();
    nb = data_len();
    pk = parity_kind();
    fire = 1'b0;
    if (rx_ph != PhIdle) fire = timer_hit(rx_tmr);
    case (rx_ph)
      PhIdle: begin
        if (rx_last && !level) begin
          rx_sr = '0;
          rx_idx = '0;
          if ((b >> 1) == '0) begin
            rx_ph = PhData;
            rx_tmr = b;
          end else begin
            rx_ph = PhStart;
            rx_tmr = b >> 1;
          end
        end
      end
      PhStart: if (fire) begin
        rx_ph = PhData;
        rx_tmr = b;
      end
      PhData: if (fire) begin
        if (level) rx_sr[rx_idx] = 1'b1;
        if (int'(rx_idx) + 1 >= nb) begin
          rx_ph = (pk != ParNone) ? PhParity : PhStop;
          rx_idx = '0;
        end else begin
          rx_idx = rx_idx + 3'd1;
        end
        rx_tmr = b;
      end
      PhParity: if (fire) begin
        calc = ^rx_sr;
        if ((pk == ParEven) ? (calc != level) : (calc == level)) begin
          rx_ph = PhIdle;
        end else begin
          rx_ph = PhStop;
          rx_tmr = b;
        end
      end
      PhStop: if (fire) begin
        if (level) store_byte(rx_sr & low_mask(nb));
        rx_ph = PhIdle;
      end
      default: rx_ph = PhIdle;
    endcase
  endfunction

  function automatic logic tx_line();
    logic l;
    case (tx_ph)
      PhStart:  l = 1'b0;
      PhData:   l = tx_sr[tx_idx];
      PhParity: l = (parity_kind() == ParEven) ? ^tx_sr : ~^tx_sr;
      default:  l = 1'b1;
    endcase
    return l;
  endfunction

  function automatic void tx_advance();
    if (tx_ph != PhIdle) begin
      if (timer_hit(tx_tmr)) begin
        tx_tmr = bit_len();
        case (tx_ph)
          PhStart: begin
            tx_ph = PhData;
            tx_idx = '0;
          end
          PhData: begin
            if (int'(tx_idx) + 1 >= data_len()) begin
              tx_ph = (parity_kind() != ParNone) ? PhParity : PhStop;
              tx_idx = '0;
            end else begin
              tx_idx = tx_idx + 3'd1;
            end
          end
          PhParity: begin
            tx_ph = PhStop;
            tx_idx = '0;
          end
          default: begin
            if (int'(tx_idx) + 1 >= stop_len()) begin
              tx_ph = PhIdle;
              tx_tmr = '0;
              tx_idx = '0;
            end else begin
              tx_idx = tx_idx + 3'd1;
            end
          end
        endcase
      end
    end
  endfunction

  // The read is served before the receiver steps, so it never sees this tick's byte.
  function automatic tick_rsp_t line_tick_predict(tick_req_t r);
    tick_rsp_t o;
    o.read_data = '0;
    o.send_taken = 1'b0;
    if (!ln_en) begin
      o.read_status = RdOff;
    end else if (rx_bytes_q.size() == 0) begin
      o.read_status = RdEmpty;
    end else if (r.read_req) begin
      o.read_status = RdOk;
      o.read_data = rx_bytes_q.pop_front();
    end else begin
      o.read_status = RdEmpty;
    end
    if (ln_en) rx_advance(r.rx_level);
    rx_last = r.rx_level;
    if (ln_en && r.send_valid && tx_ph == PhIdle) begin
      tx_sr = r.send_byte & low_mask(data_len());
      tx_ph = PhStart;
      tx_tmr = bit_len();
      tx_idx = '0;
      o.send_taken = 1'b1;
      sends_taken++;
    end
    o.tx_level = tx_line();
    o.tx_busy = (tx_ph != PhIdle);
    tx_advance();
    o.fill_level = 6'(rx_bytes_q.size());
    o.overflow = ovf_flag;
    return o;
  endfunction

  function automatic void model_reset();
    ln_ticks = tick_t'(104);
    ln_bits = 4'd8;
    ln_stop = 2'd1;
    ln_par = ParNone;
    ln_en = 1'b0;
    rx_last = 1'b1;
    clear_line();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_level(logic l, int n);
    repeat (n) line_q.push_back(l);
  endfunction

  function automatic void queue_frame(logic [7:0] value, frame_kind_e kind);
    int         b;
    int         nb;
    logic [7:0] v;
    logic       pbit;
    b = int'(bit_len());
    nb = data_len();
    v = value & low_mask(nb);
    push_level(1'b1, $urandom_range(1, 3));
    push_level(1'b0, b);
    for (int i = 0; i < nb; i++) push_level(v[i], b);
    if (parity_kind() != ParNone) begin
      pbit = (parity_kind() == ParEven) ? ^v : ~^v;
      push_level(pbit ^ (kind == FrameBadParity), b);
    end
    push_level(kind != FrameBadStop, b);
    if (stop_len() == 2) push_level(1'b1, b);
  endfunction

  function automatic void queue_noise();
    int b;
    b = int'(bit_len());
    repeat ($urandom_range(1, 6))
      push_level(1'($urandom_range(0, 1)), $urandom_range(1, 2 * b));
  endfunction

  function automatic tick_req_t mk_tick(logic rx, logic sv, logic [7:0] sb, logic rd);
    tick_req_t r;
    r.rx_level = rx;
    r.send_valid = sv;
    r.send_byte = sb;
    r.read_req = rd;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= ReportCap) $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  task automatic send_tick(input tick_req_t r);
    int gap;
    gap = src_jitter ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i <= {5'd0, r.read_req, r.send_byte, r.send_valid, r.rx_level};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    due_results.push_back(line_tick_predict(r));
    ticks_done++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    model_config(idx, val);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input tick_t ticks, input int bits, input int stops,
                           input logic [1:0] par, input logic en);
    drain();
    reg_write(RegBitTicks, 32'(ticks));
    reg_write(RegDataBits, 32'(bits));
    reg_write(RegStopCount, 32'(stops));
    reg_write(RegParity, 32'(par));
    reg_write(RegEnable, 32'(en));
    apb_release();
    line_q.delete();
    settings_run++;
  endtask

  task automatic run_traffic(input int n, input int read_pct, input int send_pct,
                             input int fault_pct, input int noise_pct);
    int        pick;
    tick_req_t r;
    repeat (n) begin
      if (line_q.size() == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < noise_pct) begin
          queue_noise();
        end else if (pick < noise_pct + fault_pct) begin
          queue_frame(8'($urandom), $urandom_range(0, 1) ? FrameBadParity : FrameBadStop);
        end else begin
          queue_frame(8'($urandom), FrameGood);
        end
      end
      r.rx_level = line_q.pop_front();
      r.send_valid = ($urandom_range(0, 99) < send_pct);
      r.send_byte = 8'($urandom);
      r.read_req = ($urandom_range(0, 99) < read_pct);
      send_tick(r);
    end
  endtask

  task automatic test_disabled_after_reset();
    send_tick(mk_tick(1'b1, 1'b1, 8'hFF, 1'b1));
    send_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 8'hAA, 1'b1));
    send_tick(mk_tick(1'b0, 1'b1, 8'h55, 1'b0));
    send_tick(mk_tick(1'b1, 1'b0, 8'hFF, 1'b1));
  endtask

  task automatic test_directed_frames();
    int i;
    configure(tick_t'(1), 8, 1, ParNone, 1'b1);
    send_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b1));
    queue_frame(8'h00, FrameGood);
    queue_frame(8'hFF, FrameGood);
    i = 0;
    while (line_q.size() != 0) begin
      send_tick(mk_tick(line_q.pop_front(), i == 0 || i == 1 || i == 12,
                        (i == 0) ? 8'hFF : 8'h00, i % 7 == 6));
      i++;
    end
    repeat (3) send_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b1));
  endtask

  task automatic test_reset_bit_rate();
    configure(tick_t'(104), 8, 1, ParNone, 1'b1);
    src_jitter = 1'b1;
    sink_jitter = 1'b1;
    run_traffic(150, 5, 2, 0, 0);
  endtask

  task automatic test_random_settings();
    logic [1:0] modes [3];
    modes = '{ParNone, ParEven, ParOdd};
    configure(tick_t'(1), 5, 1, ParNone, 1'b1);
    src_jitter = 1'b0;
    sink_jitter = 1'b0;
    run_traffic(60, 15, 30, 10, 5);
    configure(tick_t'(1), 8, 2, ParOdd, 1'b1);
    src_jitter = 1'b1;
    sink_jitter = 1'b1;
    run_traffic(60, 15, 30, 10, 5);
    for (int p = 0; p < 6; p++) begin
      configure(tick_t'($urandom_range(1, 6)), $urandom_range(5, 8), $urandom_range(1, 2),
                modes[$urandom_range(0, 2)], 1'b1);
      src_jitter = p[0];
      sink_jitter = p[1];
      run_traffic(60, 15, 30, 10, 5);
    end
  endtask

  task automatic test_fifo_overflow();
    configure(tick_t'(1), 5, 1, ParNone, 1'b1);
    src_jitter = 1'b1;
    sink_jitter = 1'b0;
    run_traffic(680, 0, 20, 0, 0);
    drain();
    // A write outside the register list must leave the FIFO and the flag alone.
    reg_write(RegUnused, $urandom);
    apb_release();
    run_traffic(100, 60, 20, 5, 5);
  endtask

  task automatic test_odd_registers();
    configure(tick_t'(0), 15, 3, 2'd3, 1'b1);
    run_traffic(60, 20, 30, 10, 10);
    configure(tick_t'(2), 0, 0, 2'd3, 1'b1);
    run_traffic(60, 20, 30, 10, 10);
  endtask

  task automatic test_disabled_traffic();
    configure(tick_t'(2), 7, 1, ParEven, 1'b0);
    run_traffic(60, 40, 40, 10, 10);
  endtask

  task automatic test_longest_bit();
    configure(20'hFFFFF, 8, 2, ParOdd, 1'b1);
    send_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b1));
    send_tick(mk_tick(1'b0, 1'b1, 8'hFF, 1'b1));
    repeat (30) send_tick(mk_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom),
                                  1'($urandom_range(0, 1))));
  endtask

  task automatic test_backpressure();
    configure(tick_t'(2), 8, 1, ParEven, 1'b1);
    src_jitter = 1'b0;
    sink_jitter = 1'b0;
    hold_left = 300;
    run_traffic(300, 30, 40, 10, 5);
    drain();
    sink_jitter = 1'b1;
    run_traffic(100, 30, 40, 10, 5);
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap = sink_gap - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (sink_jitter) sink_gap = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    tick_rsp_t   want;
    logic [23:0] d;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      d = m_axis_tdata_o;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportCap) $error("result arrived with no request outstanding");
      end else begin
        want = due_results.pop_front();
        check_field("tx_level", 32'(want.tx_level), 32'(d[0]));
        check_field("send_taken", 32'(want.send_taken), 32'(d[1]));
        check_field("tx_busy", 32'(want.tx_busy), 32'(d[2]));
        check_field("read_status", 32'(want.read_status), 32'(d[4:3]));
        check_field("read_data", 32'(want.read_data), 32'(d[12:5]));
        check_field("fill_level", 32'(want.fill_level), 32'(d[18:13]));
        check_field("overflow", 32'(want.overflow), 32'(d[19]));
      end
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled_after_reset();
    test_directed_frames();
    test_random_settings();
    test_fifo_overflow();
    test_backpressure();
    test_odd_registers();
    test_disabled_traffic();
    test_longest_bit();
    test_reset_bit_rate();
    drain();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d line ticks under %0d register settings; %0d sends were accepted.",
             ticks_done, settings_run, sends_taken);
    $display("The receiver stored %0d good bytes and dropped %0d on a full FIFO.",
             bytes_received, overflow_hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
